>>> rtl/core/code_lock_stepper_controller_core_defines.svh
// Assertion macros for the code lock stepper controller core.
// No dependencies; included by the modules that carry assertions.
`ifndef CODE_LOCK_STEPPER_CONTROLLER_CORE_DEFINES_SVH
`define CODE_LOCK_STEPPER_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CLSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CLSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/clsc_pkg.sv
// Shared constants and tables for the code lock stepper controller.
// No dependencies.
package clsc_pkg;

    localparam int DEF_CODE_LENGTH = 4;
    localparam int DEF_KEY_COUNT   = 15;

    localparam int TABLE_KEYS = 15;
    localparam int CODE_REGS  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int KEY_IDX_W  = 4;
    localparam int TURN_W     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOURTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURNS_LIMIT = 3'd4;

    // Input opcodes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [TURN_W-1:0] TURNS_LIMIT_RESET = 16'd256;

    localparam logic [31:0] KEY_TABLE [TABLE_KEYS] = '{
        32'hFF6897, 32'hFF30CF, 32'hFF18E7, 32'hFF7A85, 32'hFF10EF,
        32'hFF38C7, 32'hFF5AA5, 32'hFF42BD, 32'hFF4AB5, 32'hFF52AD,
        32'hFFC23D, 32'hFF22DD, 32'hFF906F, 32'hFFE01F, 32'hFFA25D
    };

    // Last entry pads the index space; key index 15 never occurs.
    localparam logic [6:0] SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27,
        7'h7F, 7'h6F, 7'h31, 7'h38, 7'h3E, 7'h5E, 7'h00, 7'h00
    };

    localparam logic [3:0] COIL_TABLE [8] = '{
        4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9
    };

    localparam logic [KEY_IDX_W-1:0] CODE_RESET [8] = '{
        4'd2, 4'd4, 4'd7, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0
    };

endpackage

>>> rtl/core/clsc_if.sv
// Handshake channel interfaces: key/tick items, results, config writes.
// Depends on clsc_pkg.
interface clsc_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] key_code;

    modport source (output valid, output opcode, output key_code, input ready);
    modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

interface clsc_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] segments;
    logic       key_recognized;
    logic [3:0] coils;
    logic       unlocked_mode;
    logic       moving;

    modport source (output valid, output segments, output key_recognized,
                    output coils, output unlocked_mode, output moving, input ready);
    modport sink   (input valid, input segments, input key_recognized,
                    input coils, input unlocked_mode, input moving, output ready);
endinterface

interface clsc_cfg_if;
    import clsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/code_lock_stepper_controller_core.sv
// Code lock with stepper half-step drive, single module core.
// Depends on clsc_pkg, clsc_if.sv and code_lock_stepper_controller_core_defines.svh.
//
//  channel | dir | word contents
//  --------+-----+------------------------------------------------------------
//  item    | in  | opcode (key / tick), key_code[31:0]
//  result  | out | segments, key_recognized, coils, unlocked_mode, moving
//  cfg     | in  | index[2:0], data[15:0]; always ready
//
// One word per cycle sustained while result.ready is high; the result register loads as the item leaves stage 1.
// Stage 1 is an input register; stage 2 is the state itself plus the
// recognized flag, which form the result register.
// A held result stalls stage 1 only; item.ready stays high while stage 1 can drain.
// Asynchronous active-low reset puts the lock in locked mode, counts at zero,
// display and coils dark, code and turns limit at their defaults.
`include "code_lock_stepper_controller_core_defines.svh"

module code_lock_stepper_controller_core #(
    parameter int CODE_LENGTH = clsc_pkg::DEF_CODE_LENGTH,
    parameter int KEY_COUNT   = clsc_pkg::DEF_KEY_COUNT
) (
    input  logic          clk,
    input  logic          rst_n,
    clsc_item_if.sink     item,
    clsc_result_if.source result,
    clsc_cfg_if.sink      cfg
);
    import clsc_pkg::*;

    localparam int ENTRY_W   = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int KEY_MATCH = (KEY_COUNT < TABLE_KEYS) ? KEY_COUNT : TABLE_KEYS;

    // ------------------------------------------------------------------
    // Configuration registers: code keys and turns limit
    // ------------------------------------------------------------------
    logic [KEY_IDX_W-1:0] code_reg [CODE_LENGTH];
    logic [TURN_W-1:0]    turns_limit_reg;

    logic cfg_wr;
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_code
        if (i < CODE_REGS) begin : g_wr
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    code_reg[i] <= CODE_RESET[i];
                end
                else if (cfg_wr && cfg.index == CFG_IDX_W'(i))
                begin
                    code_reg[i] <= cfg.data[KEY_IDX_W-1:0];
                end
            end
        end
        else begin : g_fixed
            // Entries past the writable registers keep their default.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    code_reg[i] <= CODE_RESET[i % 8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turns_limit_reg <= TURNS_LIMIT_RESET;
        end
        else if (cfg_wr && cfg.index == CFG_TURNS_LIMIT)
        begin
            turns_limit_reg <= cfg.data[TURN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic        s1_opcode_reg;
    logic [31:0] s1_key_reg;
    logic        res_valid_reg;
    logic        advance;

    // Stage 1 moves into the state when the result slot is free or draining.
    assign advance    = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_opcode_reg <= item.opcode;
            s1_key_reg    <= item.key_code;
        end
    end

    // ------------------------------------------------------------------
    // Key lookup: parallel compares, lowest index wins
    // ------------------------------------------------------------------
    logic                 key_hit;
    logic [KEY_IDX_W-1:0] key_idx;

    always_comb
    begin
        key_hit = 1'b0;
        key_idx = '0;
        for (int j = KEY_MATCH - 1; j >= 0; j--)
        begin
            if (s1_key_reg == KEY_TABLE[j])
            begin
                key_hit = 1'b1;
                key_idx = KEY_IDX_W'(j);
            end
        end
    end

    // ------------------------------------------------------------------
    // State / result register
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0]   entry_count_reg, entry_count_next;
    logic [KEY_IDX_W-1:0] entered_reg [CODE_LENGTH];
    logic                 go_reg, go_next;
    logic                 mode_reg, mode_next;
    logic [2:0]           phase_reg, phase_next;
    logic [TURN_W-1:0]    turn_reg, turn_next;
    logic [6:0]           display_reg, display_next;
    logic [3:0]           coil_reg, coil_next;
    logic                 recognized_reg, recognized_next;

    logic is_key, is_tick, last_entry, code_match, limit_hit;

    assign is_key     = (s1_opcode_reg == OP_KEY);
    assign is_tick    = (s1_opcode_reg == OP_TICK);
    assign last_entry = (entry_count_reg == ENTRY_W'(CODE_LENGTH - 1));
    assign limit_hit  = (turn_reg >= turns_limit_reg);

    // Stored entries ahead of the last one, plus the key arriving now.
    always_comb
    begin
        code_match = (key_idx == code_reg[CODE_LENGTH-1]);
        for (int i = 0; i < CODE_LENGTH - 1; i++)
        begin
            if (entered_reg[i] != code_reg[i])
            begin
                code_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        entry_count_next = entry_count_reg;
        go_next          = go_reg;
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        turn_next        = turn_reg;
        display_next     = display_reg;
        coil_next        = coil_reg;
        recognized_next  = 1'b0;

        if (is_key && key_hit)
        begin
            recognized_next = 1'b1;
            display_next    = SEG_TABLE[key_idx];
            if (last_entry)
            begin
                go_next          = code_match;
                entry_count_next = '0;
            end
            else
            begin
                entry_count_next = entry_count_reg + ENTRY_W'(1);
            end
        end
        else if (is_tick && go_reg)
        begin
            if (limit_hit)
            begin
                // Flip mode and park; no step on this tick.
                mode_next  = !mode_reg;
                go_next    = 1'b0;
                phase_next = mode_reg ? 3'd7 : 3'd0;
                turn_next  = '0;
            end
            else
            begin
                if (mode_reg)
                begin
                    phase_next = phase_reg + 3'd1;
                    if (phase_reg == 3'd7)
                    begin
                        turn_next = turn_reg + TURN_W'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg - 3'd1;
                    if (phase_reg == 3'd0)
                    begin
                        turn_next = turn_reg + TURN_W'(1);
                    end
                end
                coil_next = COIL_TABLE[phase_next];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
            go_reg          <= 1'b0;
            mode_reg        <= 1'b0;
            phase_reg       <= 3'd0;
            turn_reg        <= '0;
            display_reg     <= '0;
            coil_reg        <= '0;
            recognized_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                res_valid_reg   <= 1'b1;
                entry_count_reg <= entry_count_next;
                go_reg          <= go_next;
                mode_reg        <= mode_next;
                phase_reg       <= phase_next;
                turn_reg        <= turn_next;
                display_reg     <= display_next;
                coil_reg        <= coil_next;
                recognized_reg  <= recognized_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Entered keys: no reset, only read after being written this round.
    for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_entry
        always_ff @(posedge clk)
        begin
            if (advance && is_key && key_hit && entry_count_reg == ENTRY_W'(i))
            begin
                entered_reg[i] <= key_idx;
            end
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.segments       = display_reg;
    assign result.key_recognized = recognized_reg;
    assign result.coils          = coil_reg;
    assign result.unlocked_mode  = mode_reg;
    assign result.moving         = go_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CLSC_ASSERT_NEXT(a_flip_parks, clk, rst_n,
        advance && is_tick && go_reg && limit_hit,
        !go_reg && mode_reg != $past(mode_reg) && turn_reg == '0,
        "mode flip did not park the motor")
    `CLSC_ASSERT_NEXT(a_unknown_key_idle, clk, rst_n,
        advance && is_key && !key_hit,
        $stable(entry_count_reg) && $stable(display_reg) && !recognized_reg,
        "unknown key changed lock state")
    `CLSC_ASSERT_NOW(a_count_bound, clk, rst_n,
        1'b1, entry_count_reg <= ENTRY_W'(CODE_LENGTH - 1),
        "entry count past code length")
    `CLSC_ASSERT_NEXT(a_coils_stay_on, clk, rst_n,
        coil_reg != 4'd0, coil_reg != 4'd0,
        "coil pattern went dark after stepping")
    `CLSC_ASSERT_NEXT(a_result_follows, clk, rst_n,
        advance, res_valid_reg,
        "processed word produced no result")

endmodule

>>> bench/code_lock_stepper_controller_core_test.sv
// Self-checking bench for code_lock_stepper_controller_core: a directed table, then random phases.
// Depends on clsc_pkg and the channel interfaces in clsc_if.sv.
`timescale 1ns / 1ps

module code_lock_stepper_controller_core_test;
    import clsc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PERCENT   = 29;
    localparam int HOLD_CYCLES    = 64;    // receiver hold-off, long enough to back up the pipe
    localparam int DRAIN_CYCLES   = 4;     // margin after the last expected result word
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 125;   // minimum words sent per phase

    // One result word, in port order
    typedef struct packed {
        logic [6:0] segments;
        logic       key_recognized;
        logic [3:0] coils;
        logic       unlocked_mode;
        logic       moving;
    } lock_word_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // Directed row: either an input word or a register write.
    // fixed rows carry an expectation that can be read straight off the spec.
    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          value;
        bit                   fixed;
        lock_word_t           want;
    } stim_row_t;

    localparam lock_word_t NO_CHECK = '0;
    localparam int DIRECTED_ROWS = 32;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Out of reset: tick with the motor stopped, unknown codes at both extremes
        '{ROW_ITEM, OP_TICK, CFG_CODE_FIRST, 32'hFFFF_FFFF, 1'b1, '{7'h00, 1'b0, 4'h0, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, 32'h0000_0000, 1'b1, '{7'h00, 1'b0, 4'h0, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, 32'hFFFF_FFFF, 1'b1, '{7'h00, 1'b0, 4'h0, 1'b0, 1'b0}},
        // First and last table keys, then a wrong code clears the count
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[0],  1'b1, '{7'h3F, 1'b1, 4'h0, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[14], 1'b1, '{7'h00, 1'b1, 4'h0, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[13], 1'b1, '{7'h5E, 1'b1, 4'h0, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[1],  1'b1, '{7'h06, 1'b1, 4'h0, 1'b0, 1'b0}},
        // Default code opens the lock, two locked-mode steps (one wrap)
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[2],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[4],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[7],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[7],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, CFG_CODE_FIRST, 32'h5A5A_A5A5, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, CFG_CODE_FIRST, 32'hA5A5_5A5A, 1'b0, NO_CHECK},
        // Limit dropped to zero under a running count: next go tick flips mode
        '{ROW_CFG,  OP_KEY,  CFG_TURNS_LIMIT, 32'd0,        1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, CFG_CODE_FIRST, 32'h0000_0000, 1'b0, NO_CHECK},
        // Code with an impossible entry (index 15) never opens; limit at max
        '{ROW_CFG,  OP_KEY,  CFG_CODE_FIRST,  32'd0,        1'b0, NO_CHECK},
        '{ROW_CFG,  OP_KEY,  CFG_CODE_SECOND, 32'd14,       1'b0, NO_CHECK},
        '{ROW_CFG,  OP_KEY,  CFG_CODE_THIRD,  32'd15,       1'b0, NO_CHECK},
        '{ROW_CFG,  OP_KEY,  CFG_CODE_FOURTH, 32'd0,        1'b0, NO_CHECK},
        '{ROW_CFG,  OP_KEY,  CFG_TURNS_LIMIT, 32'hFFFF,     1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[0],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[14], 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[14], 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[0],  1'b0, NO_CHECK},
        // Extreme key indexes as the code, limit of one; steps up in unlocked mode
        '{ROW_CFG,  OP_KEY,  CFG_CODE_THIRD,  32'd13,       1'b0, NO_CHECK},
        '{ROW_CFG,  OP_KEY,  CFG_TURNS_LIMIT, 32'd1,        1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[0],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[14], 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[13], 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_KEY,  CFG_CODE_FIRST, KEY_TABLE[0],  1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, CFG_CODE_FIRST, 32'h1234_5678, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, CFG_CODE_FIRST, 32'h8765_4321, 1'b0, NO_CHECK}
    };

    logic clk;
    logic rst_n;

    clsc_item_if   item_ch ();
    clsc_result_if result_ch ();
    clsc_cfg_if    cfg_ch ();

    code_lock_stepper_controller_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Lock model state; the declared values are the post-reset state
    logic [KEY_IDX_W-1:0] code_want [DEF_CODE_LENGTH];
    logic [TURN_W-1:0]    flip_turns = TURNS_LIMIT_RESET;
    int                   entries_done = 0;
    logic [KEY_IDX_W-1:0] entered [DEF_CODE_LENGTH];
    bit                   motor_go = 1'b0;
    bit                   open_mode = 1'b0;
    logic [2:0]           phase = '0;
    logic [TURN_W-1:0]    wraps = '0;
    logic [6:0]           shown_segments = '0;
    logic [3:0]           coil_drive = '0;

    lock_word_t pending_words [$];   // expected result words, oldest first

    int  items_sent = 0;
    int  active_items = 0;           // recognized keys and ticks that stepped or flipped
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  mismatches = 0;
    int  opens = 0;
    int  flips = 0;
    int  idle_cycles = 0;
    int  holds_asked = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    bit  quiet_stretch = 1'b0;       // neither side idles
    bit  sender_steady = 1'b0;       // sender never idles

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the lock model by one input word and return the word it should produce.
    function automatic lock_word_t advance_lock(input logic op, input logic [31:0] key);
        lock_word_t           w;
        bit                   hit;
        bit                   all_match;
        logic [KEY_IDX_W-1:0] slot;
        int                   j;
        hit  = 1'b0;
        slot = '0;
        if (op == OP_KEY) begin
            for (j = 0; j < TABLE_KEYS; j++)
            begin
                if (!hit && KEY_TABLE[j] == key)
                begin
                    hit  = 1'b1;
                    slot = j[KEY_IDX_W-1:0];
                end
            end
            if (hit)
            begin
                entered[entries_done] = slot;
                entries_done++;
                shown_segments = SEG_TABLE[slot];
                // Full code entered: compare and restart the count either way
                if (entries_done == DEF_CODE_LENGTH)
                begin
                    all_match = 1'b1;
                    for (j = 0; j < DEF_CODE_LENGTH; j++)
                    begin
                        if (entered[j] != code_want[j])
                            all_match = 1'b0;
                    end
                    if (all_match && !motor_go)
                        opens++;
                    motor_go     = all_match;
                    entries_done = 0;
                end
            end
        end
        else if (motor_go)
        begin
            if (wraps >= flip_turns)
            begin
                // Limit reached: flip mode, stop, preset phase; no step this tick
                open_mode = !open_mode;
                motor_go  = 1'b0;
                phase     = open_mode ? 3'd0 : 3'd7;
                wraps     = '0;
                flips++;
            end
            else
            begin
                // Up in unlocked mode, down in locked mode; each wrap is a turn
                if (open_mode)
                begin
                    if (phase == 3'd7)
                        wraps++;
                    phase = phase + 3'd1;
                end
                else
                begin
                    if (phase == 3'd0)
                        wraps++;
                    phase = phase - 3'd1;
                end
                coil_drive = COIL_TABLE[phase];
            end
        end
        w.segments       = shown_segments;
        w.key_recognized = hit;
        w.coils          = coil_drive;
        w.unlocked_mode  = open_mode;
        w.moving         = motor_go;
        return w;
    endfunction

    // Offer one input word, hold it until accepted, then log its expected result.
    task automatic send_word(input logic op, input logic [31:0] key, input bit fixed,
                             input lock_word_t want);
        lock_word_t predicted;
        bit         was_moving;
        item_ch.valid    <= 1'b1;
        item_ch.opcode   <= op;
        item_ch.key_code <= key;
        do @(posedge clk); while (!item_ch.ready);
        was_moving = motor_go;
        predicted  = advance_lock(op, key);
        if (predicted.key_recognized || (op == OP_TICK && was_moving))
            active_items++;
        items_sent++;
        pending_words.push_back(fixed ? want : predicted);
        // Random idle cycles after the word, each drawn on its own
        if (!quiet_stretch && !sender_steady)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Stop sending and let every expected word come back before touching registers.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg valid after the last of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx < CODE_REGS)
            code_want[idx[1:0]] = value[KEY_IDX_W-1:0];
        else if (idx == CFG_TURNS_LIMIT)
            flip_turns = value;
        cfg_writes++;
    endtask

    task automatic compare_field(input string field, input logic [6:0] want, input logic [6:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Compare an accepted result word with the oldest expectation.
    task automatic check_word();
        lock_word_t want;
        results_seen++;
        if (pending_words.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual seg %0h coils %0h",
                     $time, result_ch.segments, result_ch.coils);
        end
        else
        begin
            want = pending_words.pop_front();
            compare_field("segments", want.segments, result_ch.segments);
            compare_field("key_recognized", 7'(want.key_recognized), 7'(result_ch.key_recognized));
            compare_field("coils", 7'(want.coils), 7'(result_ch.coils));
            compare_field("unlocked_mode", 7'(want.unlocked_mode), 7'(result_ch.unlocked_mode));
            compare_field("moving", 7'(want.moving), 7'(result_ch.moving));
        end
    endtask

    // Result side: check at each edge, then pick ready for the next cycle.
    // A hold-off request drops ready for a fixed stretch so the block backs up.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_word();
            if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence
    initial
    begin
        int                   r;
        int                   p;
        int                   i;
        int                   pick;
        int                   bad_pos;
        int                   start_sent;
        logic [KEY_IDX_W-1:0] slot;
        logic [KEY_IDX_W-1:0] code_val;
        logic [11:0]          upper;
        logic [TURN_W-1:0]    limit;
        logic [31:0]          noise;

        for (i = 0; i < DEF_CODE_LENGTH; i++)
        begin
            code_want[i] = CODE_RESET[i];
            entered[i]   = '0;
        end

        rst_n            <= 1'b0;
        item_ch.valid    <= 1'b0;
        item_ch.opcode   <= OP_KEY;
        item_ch.key_code <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_CODE_FIRST;
        cfg_ch.data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; register writes wait for the pipe to empty first
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                if (r == 0 || DIRECTED[r - 1].kind != ROW_CFG)
                    drain_results();
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value[CFG_DATA_W-1:0]);
                if (r == DIRECTED_ROWS - 1 || DIRECTED[r + 1].kind != ROW_CFG)
                    cfg_ch.valid <= 1'b0;
            end
            else
                send_word(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].fixed, DIRECTED[r].want);
        end

        // Random phases, each with a fresh code and turns limit.
        // Phase 0 runs with no idling at all; phases 4 and 8 stall the receiver
        // while the sender keeps offering words.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            quiet_stretch = (p == 0);
            sender_steady = (p == 4 || p == 8);
            for (i = 0; i < DEF_CODE_LENGTH; i++)
            begin
                // Mostly valid key indexes, now and then the impossible 15
                code_val = ($urandom_range(9) == 0) ? 4'hF : 4'($urandom_range(TABLE_KEYS - 1));
                upper    = ($urandom_range(3) == 0) ? 12'($urandom()) : '0;
                write_reg(CFG_CODE_FIRST + 3'(i), {upper, code_val});
            end
            case (p)
                1:       limit = '1;
                2:       limit = '0;
                5:       limit = 16'($urandom_range(4, 12));
                default: limit = 16'($urandom_range(1, 3));
            endcase
            write_reg(CFG_TURNS_LIMIT, limit);
            cfg_ch.valid <= 1'b0;
            if (sender_steady)
                holds_asked++;

            start_sent = items_sent;
            while (items_sent - start_sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // Code entry: well formed below 55, otherwise one entry spoiled
                    bad_pos = (pick < 55) ? DEF_CODE_LENGTH : $urandom_range(DEF_CODE_LENGTH - 1);
                    while (entries_done != 0)
                        send_word(OP_KEY, KEY_TABLE[$urandom_range(TABLE_KEYS - 1)], 1'b0, NO_CHECK);
                    for (i = 0; i < DEF_CODE_LENGTH; i++)
                    begin
                        if (i == bad_pos || code_want[i] >= TABLE_KEYS)
                            slot = 4'($urandom_range(TABLE_KEYS - 1));
                        else
                            slot = code_want[i];
                        send_word(OP_KEY, KEY_TABLE[slot], 1'b0, NO_CHECK);
                    end
                    if (pick < 55)
                        repeat ($urandom_range(1, 30))
                            send_word(OP_TICK, $urandom(), 1'b0, NO_CHECK);
                end
                else if (pick < 85)
                begin
                    // Noise: fully random codes or table keys with one bit flipped
                    if ($urandom_range(1) == 0)
                        noise = $urandom();
                    else
                        noise = KEY_TABLE[$urandom_range(TABLE_KEYS - 1)]
                                ^ (32'h1 << $urandom_range(31));
                    send_word(OP_KEY, noise, 1'b0, NO_CHECK);
                end
                else
                    repeat ($urandom_range(1, 4))
                        send_word(OP_TICK, $urandom(), 1'b0, NO_CHECK);
            end
        end

        quiet_stretch = 1'b0;
        sender_steady = 1'b0;
        drain_results();

        $display("Sent %0d words (%0d moved the lock), checked %0d results, %0d register writes.",
                 items_sent, active_items, results_seen, cfg_writes);
        $display("Lock opened %0d times, mode flipped %0d times, %0d mismatches.",
                 opens, flips, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
